// ===== rtl/core/amle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package amle_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int MAX_EDGES    = 64;

   localparam int VTX_W    = 5;
   localparam int SLOT_W   = 6;
   localparam int USED_W   = 7;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 2;

   localparam int VADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int EADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   // link store: two links per edge, addressed {slot, end}
   localparam int LADDR_W = EADDR_W + 1;
   localparam int LINK_DEPTH = 2 * MAX_EDGES;

   localparam logic [COUNT_W-1:0] VCOUNT_RESET = COUNT_W'(32);

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_LIST = 1'b1;

   localparam int END_FIRST  = 0;
   localparam int END_SECOND = 1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // per-vertex entry: chain head, chain tail and which links of the tail
   // edge belong to this vertex
   typedef struct packed {
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] tail;
      logic [1:0]        mask;
   } vent_type;

   typedef struct packed {
      logic [VTX_W-1:0] fe;
      logic [VTX_W-1:0] se;
   } eend_type;

   localparam int VENT_W = $bits(vent_type);
   localparam int EEND_W = $bits(eend_type);

   typedef struct packed {
      logic               we;
      logic [VADDR_W-1:0] waddr;
      vent_type           wdata;
      logic               re;
      logic [VADDR_W-1:0] raddr;
   } vram_req_type;

   typedef struct packed {
      logic               we;
      logic [EADDR_W-1:0] waddr;
      eend_type           wdata;
      logic               re;
      logic [EADDR_W-1:0] raddr;
   } eram_req_type;

   typedef struct packed {
      logic               we;
      logic [LADDR_W-1:0] waddr;
      logic [SLOT_W-1:0]  wdata;
      logic               re;
      logic [LADDR_W-1:0] raddr;
   } lram_req_type;

endpackage

`default_nettype wire

// ===== rtl/core/amle_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module amle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/amle_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module amle_ctrl
   import amle_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [COUNT_W-1:0]  vertex_count,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_cmd,
   input  wire logic [VTX_W-1:0]    req_vertex_a,
   input  wire logic [VTX_W-1:0]    req_vertex_b,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_edge_index,
   output logic [VTX_W-1:0]         rsp_first_end,
   output logic [VTX_W-1:0]         rsp_second_end,
   output logic [VTX_W-1:0]         rsp_other_end,
   output logic                     rsp_empty_res,
   output logic                     rsp_last,
   output vram_req_type             vram_req,
   input  wire vent_type            vram_rdata,
   output eram_req_type             eram_req,
   input  wire eend_type            eram_rdata,
   output lram_req_type             lram_req,
   input  wire logic [SLOT_W-1:0]   lram_rdata
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_VRD  = 8'b0000_0010,
      S_LNK0 = 8'b0000_0100,
      S_LNK1 = 8'b0000_1000,
      S_VWR  = 8'b0001_0000,
      S_LHD  = 8'b0010_0000,
      S_LRD  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [MAX_VERTICES-1:0] vvalid_ff, vvalid_in;
   logic [USED_W-1:0]       used_ff, used_in;
   logic [VTX_W-1:0]        a_ff, a_in;
   logic [VTX_W-1:0]        b_ff, b_in;
   logic                    ph_ff, ph_in;
   vent_type                ent_ff, ent_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [SLOT_W-1:0]       tail_ff, tail_in;

   status_type              rs_status_ff, rs_status_in;
   logic [SLOT_W-1:0]       rs_index_ff, rs_index_in;
   logic [VTX_W-1:0]        rs_fe_ff, rs_fe_in;
   logic [VTX_W-1:0]        rs_se_ff, rs_se_in;
   logic [VTX_W-1:0]        rs_oe_ff, rs_oe_in;
   logic                    rs_empty_ff, rs_empty_in;
   logic                    rs_last_ff, rs_last_in;

   logic                    accept;
   logic                    a_ok;
   logic                    b_ok;
   logic                    full;
   logic [VTX_W-1:0]        cur;
   logic [VADDR_W-1:0]      cur_idx;
   logic                    cur_valid;
   logic [SLOT_W-1:0]       new_slot;
   logic                    sel;

   assign accept    = req_valid && !req_stall;
   assign a_ok      = ({1'b0, req_vertex_a} < vertex_count) &&
                      (32'(req_vertex_a) < 32'(MAX_VERTICES));
   assign b_ok      = ({1'b0, req_vertex_b} < vertex_count) &&
                      (32'(req_vertex_b) < 32'(MAX_VERTICES));
   assign full      = (used_ff >= USED_W'(MAX_EDGES));
   assign cur       = ph_ff ? b_ff : a_ff;
   assign cur_idx   = VADDR_W'(cur);
   assign cur_valid = vvalid_ff[cur_idx];
   assign new_slot  = SLOT_W'(used_ff);
   // follow the second-end link unless the queried vertex is the first end
   assign sel       = (eram_rdata.fe != a_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in     = state_ff;
      vvalid_in    = vvalid_ff;
      used_in      = used_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ph_in        = ph_ff;
      ent_in       = ent_ff;
      slot_in      = slot_ff;
      tail_in      = tail_ff;
      rs_status_in = rs_status_ff;
      rs_index_in  = rs_index_ff;
      rs_fe_in     = rs_fe_ff;
      rs_se_in     = rs_se_ff;
      rs_oe_in     = rs_oe_ff;
      rs_empty_in  = rs_empty_ff;
      rs_last_in   = rs_last_ff;

      vram_req       = '0;
      vram_req.raddr = (state_ff == S_IDLE) ? VADDR_W'(req_vertex_a) : VADDR_W'(b_ff);
      eram_req       = '0;
      lram_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               a_in         = req_vertex_a;
               b_in         = req_vertex_b;
               ph_in        = 1'b0;
               vram_req.re  = 1'b1;
               rs_status_in = ST_OK;
               rs_index_in  = '0;
               rs_fe_in     = '0;
               rs_se_in     = '0;
               rs_oe_in     = '0;
               rs_empty_in  = 1'b0;
               rs_last_in   = 1'b1;
               if (req_cmd == CMD_ADD) begin
                  if (!(a_ok && b_ok)) begin
                     rs_status_in = ST_RANGE;
                     state_in     = S_OUT;
                  end else if (full) begin
                     rs_status_in = ST_FULL;
                     state_in     = S_OUT;
                  end else begin
                     state_in = S_VRD;
                  end
               end else begin
                  if (!a_ok) begin
                     rs_status_in = ST_RANGE;
                     state_in     = S_OUT;
                  end else begin
                     state_in = S_LHD;
                  end
               end
            end
         end
         S_VRD: begin
            ent_in   = vram_rdata;
            state_in = S_LNK0;
         end
         S_LNK0: begin
            // point the old tail's link for this vertex at the new slot
            lram_req.we    = cur_valid && ent_ff.mask[END_FIRST];
            lram_req.waddr = {EADDR_W'(ent_ff.tail), 1'b0};
            lram_req.wdata = new_slot;
            state_in       = S_LNK1;
         end
         S_LNK1: begin
            lram_req.we    = cur_valid && ent_ff.mask[END_SECOND];
            lram_req.waddr = {EADDR_W'(ent_ff.tail), 1'b1};
            lram_req.wdata = new_slot;
            state_in       = S_VWR;
         end
         S_VWR: begin
            vram_req.we         = 1'b1;
            vram_req.waddr      = cur_idx;
            vram_req.wdata.head = cur_valid ? ent_ff.head : new_slot;
            vram_req.wdata.tail = new_slot;
            if (!ph_ff) begin
               vram_req.wdata.mask = {(a_ff == b_ff), 1'b1};
            end else begin
               vram_req.wdata.mask = 2'b10;
            end
            vvalid_in[cur_idx] = 1'b1;
            if (!ph_ff && (a_ff != b_ff)) begin
               // second endpoint
               ph_in       = 1'b1;
               vram_req.re = 1'b1;
               state_in    = S_VRD;
            end else begin
               eram_req.we       = 1'b1;
               eram_req.waddr    = EADDR_W'(used_ff);
               eram_req.wdata.fe = a_ff;
               eram_req.wdata.se = b_ff;
               used_in           = used_ff + USED_W'(1);
               rs_status_in      = ST_OK;
               rs_index_in       = new_slot;
               rs_fe_in          = a_ff;
               rs_se_in          = b_ff;
               rs_oe_in          = '0;
               rs_empty_in       = 1'b0;
               rs_last_in        = 1'b1;
               state_in          = S_OUT;
            end
         end
         S_LHD: begin
            if (!cur_valid) begin
               rs_empty_in = 1'b1;
               state_in    = S_OUT;
            end else begin
               slot_in        = vram_rdata.head;
               tail_in        = vram_rdata.tail;
               eram_req.re    = 1'b1;
               eram_req.raddr = EADDR_W'(vram_rdata.head);
               state_in       = S_LRD;
            end
         end
         S_LRD: begin
            lram_req.re    = 1'b1;
            lram_req.raddr = {EADDR_W'(slot_ff), sel};
            rs_status_in   = ST_OK;
            rs_index_in    = slot_ff;
            rs_fe_in       = eram_rdata.fe;
            rs_se_in       = eram_rdata.se;
            rs_oe_in       = sel ? eram_rdata.fe : eram_rdata.se;
            rs_empty_in    = 1'b0;
            rs_last_in     = (slot_ff == tail_ff);
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (rs_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  // advance along the chain
                  slot_in        = lram_rdata;
                  eram_req.re    = 1'b1;
                  eram_req.raddr = EADDR_W'(lram_rdata);
                  state_in       = S_LRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vvalid_ff <= '0;
         used_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         vvalid_ff <= vvalid_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      ph_ff        <= ph_in;
      ent_ff       <= ent_in;
      slot_ff      <= slot_in;
      tail_ff      <= tail_in;
      rs_status_ff <= rs_status_in;
      rs_index_ff  <= rs_index_in;
      rs_fe_ff     <= rs_fe_in;
      rs_se_ff     <= rs_se_in;
      rs_oe_ff     <= rs_oe_in;
      rs_empty_ff  <= rs_empty_in;
      rs_last_ff   <= rs_last_in;
   end

   assign rsp_status     = rs_status_ff;
   assign rsp_edge_index = rs_index_ff;
   assign rsp_first_end  = rs_fe_ff;
   assign rsp_second_end = rs_se_ff;
   assign rsp_other_end  = rs_oe_ff;
   assign rsp_empty_res  = rs_empty_ff;
   assign rsp_last       = rs_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/adjacency_multilist_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake           Word
// req      req_valid/stall     req_cmd, req_vertex_a, req_vertex_b
// rsp      rsp_valid/stall     status, edge_index, first/second/other_end, empty_res, last
// csr      csr_valid/ready     csr_wdata (vertex_count)
//
// Add: each distinct endpoint passes S_VRD, S_LNK0, S_LNK1 and S_VWR, then the result
// word; the vertex store has one read and one write port, and the two endpoints are read and updated in turn.
// List: the head read (S_LHD), then per edge on the chain the link read (S_LRD), then
// the rsp word with the next edge read (S_OUT); up to MAX_EDGES words.
// Reset clears the vertex valid bits and the edge count; no clearing pass.
// A stalled rsp word holds the sequencer; req stays stalled until last goes out.

module adjacency_multilist_engine
   import amle_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_cmd,
   input  wire logic [VTX_W-1:0]    req_vertex_a,
   input  wire logic [VTX_W-1:0]    req_vertex_b,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_edge_index,
   output logic [VTX_W-1:0]         rsp_first_end,
   output logic [VTX_W-1:0]         rsp_second_end,
   output logic [VTX_W-1:0]         rsp_other_end,
   output logic                     rsp_empty_res,
   output logic                     rsp_last,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [COUNT_W-1:0]  csr_wdata
);

   logic [COUNT_W-1:0] vcount_ff, vcount_in;

   vram_req_type      vram_req;
   vent_type          vram_rdata;
   eram_req_type      eram_req;
   eend_type          eram_rdata;
   lram_req_type      lram_req;
   logic [SLOT_W-1:0] lram_rdata;

   assign csr_ready = 1'b1;
   assign vcount_in = (csr_valid && csr_ready) ? csr_wdata : vcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   amle_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .vertex_count   (vcount_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_edge_index (rsp_edge_index),
      .rsp_first_end  (rsp_first_end),
      .rsp_second_end (rsp_second_end),
      .rsp_other_end  (rsp_other_end),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_last       (rsp_last),
      .vram_req       (vram_req),
      .vram_rdata     (vram_rdata),
      .eram_req       (eram_req),
      .eram_rdata     (eram_rdata),
      .lram_req       (lram_req),
      .lram_rdata     (lram_rdata)
   );

   amle_ram #(
      .WIDTH (VENT_W),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (vram_req.we),
      .wr_addr (vram_req.waddr),
      .wr_data (vram_req.wdata),
      .rd_en   (vram_req.re),
      .rd_addr (vram_req.raddr),
      .rd_data (vram_rdata)
   );

   amle_ram #(
      .WIDTH (EEND_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (eram_req.we),
      .wr_addr (eram_req.waddr),
      .wr_data (eram_req.wdata),
      .rd_en   (eram_req.re),
      .rd_addr (eram_req.raddr),
      .rd_data (eram_rdata)
   );

   amle_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (lram_req.we),
      .wr_addr (lram_req.waddr),
      .wr_data (lram_req.wdata),
      .rd_en   (lram_req.re),
      .rd_addr (lram_req.raddr),
      .rd_data (lram_rdata)
   );

endmodule

`default_nettype wire
